@@ rtl/core/circular_event_log_defines.svh @@
// assertion macros for the circular event log
// used by the top level; no other dependencies
`ifndef CIRCULAR_EVENT_LOG_DEFINES_SVH
`define CIRCULAR_EVENT_LOG_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define CEL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circular_event_log: same-cycle check failed");

// antecedent holds, consequent holds in the next cycle
`define CEL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circular_event_log: next-cycle check failed");

`endif

@@ rtl/core/cel_pkg.sv @@
// shared types and constants of the circular event log
// no dependencies
package cel_pkg;

  localparam int LOG_DEPTH_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int NUM_W         = 5;    // holds 0 .. MAX_RESULTS

  // function codes
  localparam logic [1:0] FUNC_SAVE  = 2'd0;
  localparam logic [1:0] FUNC_DUMP  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_CODE_LIMIT = 1'b0;
  localparam logic CFG_EXTRA_CODE = 1'b1;

  localparam logic [5:0] TIME_LIMIT  = 6'd59;
  localparam logic [7:0] SEQ_RESTART = 8'd1;
  localparam logic [7:0] CODE_LIMIT_RST = 8'd7;
  localparam logic [7:0] EXTRA_CODE_RST = 8'd255;

  typedef struct packed {
    logic [7:0] seq;
    logic [5:0] minute;
    logic [5:0] second;
    logic [7:0] code;
    logic [7:0] sum;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

@@ rtl/core/cel_ram.sv @@
// generic single write port, single read port ram with registered read
// depends on cel_pkg for default sizes
module cel_ram
  import cel_pkg::*;
#(
  parameter int WIDTH = REC_W,
  parameter int DEPTH = LOG_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/circular_event_log.sv @@
// circular event log: ring of timestamped warning records with dump and clear
// depends on cel_pkg, cel_ram and circular_event_log_defines.svh
//
// channel   signals                                       handshake
// command   start, func, minute, second, event_code       start & !busy
// result    strobe, status .. last                        strobe, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data     cfg_valid & cfg_ready
//
// save, clear, unused code, empty dump: execute state, then idle for the next start taken
// dump: execute, then per record a ram read and an emit with checksum check, at most 16 records
// the single xor checksum unit is shared by the save and dump paths
// synchronous reset, no clearing pass: the record ram is only read where written
// results cannot be stalled; start is taken again in the cycle of the final strobe
`include "circular_event_log_defines.svh"

module circular_event_log
  import cel_pkg::*;
#(
  parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // command
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [5:0] minute,
  input  logic [5:0] second,
  input  logic [7:0] event_code,
  // result
  output logic       strobe,
  output logic       status,
  output logic       has_record,
  output logic [3:0] position,
  output logic [7:0] seq,
  output logic [5:0] rec_minute,
  output logic [5:0] rec_second,
  output logic [7:0] rec_code,
  output logic       checksum_ok,
  output logic [4:0] count,
  output logic       last,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int SLOT_W = $clog2(LOG_DEPTH);
  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > NUM_W) ? CNT_W : NUM_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;

  // header
  logic [SLOT_W-1:0] write_slot;
  logic [CNT_W-1:0]  entry_count;
  logic [7:0]        next_sequence;

  // configuration registers
  logic [7:0] code_limit;
  logic [7:0] extra_code;

  // latched command
  logic [1:0] cmd_func;
  logic [5:0] cmd_minute;
  logic [5:0] cmd_second;
  logic [7:0] cmd_code;

  // dump walk
  logic [SLOT_W-1:0] rd_addr;
  logic [NUM_W-1:0]  dump_pos;
  logic [NUM_W-1:0]  dump_total;

  // ram side
  logic              ram_we;
  rec_t              ram_wdata;
  logic              ram_re;
  logic [REC_W-1:0]  ram_rdata;
  rec_t              rd_rec;

  // shared checksum unit
  logic [7:0] sum_seq;
  logic [5:0] sum_min;
  logic [5:0] sum_sec;
  logic [7:0] sum_code;
  logic [7:0] sum_out;

  logic              save_ok;
  logic [SLOT_W-1:0] slot_inc;
  logic [SLOT_W-1:0] rd_addr_inc;
  logic [CNT_W-1:0]  count_sat;
  logic [7:0]        seq_inc;
  logic [NUM_W-1:0]  dump_n;
  logic [NUM_W-1:0]  dump_pos_inc;
  logic              dump_done;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_rec    = rec_t'(ram_rdata);

  // operands come from the latched command on a save, from the ram on a dump
  always_comb begin
    if (state == S_EMIT) begin
      sum_seq  = rd_rec.seq;
      sum_min  = rd_rec.minute;
      sum_sec  = rd_rec.second;
      sum_code = rd_rec.code;
    end else begin
      sum_seq  = next_sequence;
      sum_min  = cmd_minute;
      sum_sec  = cmd_second;
      sum_code = cmd_code;
    end
    sum_out = sum_seq ^ {2'b00, sum_min} ^ {2'b00, sum_sec} ^ sum_code;
  end

  // save argument check: time stamps up to 59, code up to limit or the extra code
  assign save_ok = ((cmd_code <= code_limit) || (cmd_code == extra_code)) &&
                   (cmd_minute <= TIME_LIMIT) && (cmd_second <= TIME_LIMIT);

  // ring pointers wrap at the depth, not at a power of two
  assign slot_inc    = (write_slot == SLOT_W'(LOG_DEPTH - 1)) ? '0 : write_slot + 1'b1;
  assign rd_addr_inc = (rd_addr == SLOT_W'(LOG_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
  assign count_sat   = (entry_count == CNT_W'(LOG_DEPTH)) ? entry_count
                                                          : entry_count + 1'b1;
  // sequence skips zero on wrap
  assign seq_inc     = (next_sequence == 8'hff) ? SEQ_RESTART : next_sequence + 8'd1;

  // a dump emits at most MAX_RESULTS records
  assign dump_n = (CMP_W'(entry_count) > CMP_W'(MAX_RESULTS)) ? NUM_W'(MAX_RESULTS)
                                                              : NUM_W'(entry_count);
  assign dump_pos_inc = dump_pos + 1'b1;
  assign dump_done    = (dump_pos_inc == dump_total);

  // record write happens in the execute cycle of an accepted save
  assign ram_we    = (state == S_EXEC) && (cmd_func == FUNC_SAVE) && save_ok;
  assign ram_wdata = '{seq: next_sequence, minute: cmd_minute, second: cmd_second,
                       code: cmd_code, sum: sum_out};
  assign ram_re    = (state == S_READ);

  cel_ram #(
    .WIDTH (REC_W),
    .DEPTH (LOG_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      code_limit <= CODE_LIMIT_RST;
      extra_code <= EXTRA_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CODE_LIMIT: code_limit <= cfg_data;
        CFG_EXTRA_CODE: extra_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_func   <= func;
      cmd_minute <= minute;
      cmd_second <= second;
      cmd_code   <= event_code;
    end
  end

  // sequencer, header and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_slot    <= '0;
      entry_count   <= '0;
      next_sequence <= SEQ_RESTART;
      strobe        <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // default result shape: no record, final
          status      <= 1'b0;
          has_record  <= 1'b0;
          position    <= '0;
          seq         <= '0;
          rec_minute  <= '0;
          rec_second  <= '0;
          rec_code    <= '0;
          checksum_ok <= 1'b0;
          count       <= 5'(entry_count);
          last        <= 1'b1;
          strobe      <= 1'b1;
          state       <= S_IDLE;
          case (cmd_func)
            FUNC_SAVE: begin
              if (save_ok) begin
                seq           <= next_sequence;
                count         <= 5'(count_sat);
                write_slot    <= slot_inc;
                entry_count   <= count_sat;
                next_sequence <= seq_inc;
              end else begin
                status <= 1'b1;
              end
            end
            FUNC_DUMP: begin
              // empty log gives the single no-record result above
              if (entry_count != '0) begin
                strobe     <= 1'b0;
                state      <= S_READ;
                rd_addr    <= (entry_count == CNT_W'(LOG_DEPTH)) ? write_slot : '0;
                dump_pos   <= '0;
                dump_total <= dump_n;
              end
            end
            FUNC_CLEAR: begin
              write_slot    <= '0;
              entry_count   <= '0;
              next_sequence <= SEQ_RESTART;
              count         <= '0;
            end
            default: ;  // unused code: plain ok result, state untouched
          endcase
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          status      <= 1'b0;
          has_record  <= 1'b1;
          position    <= dump_pos[3:0];
          seq         <= rd_rec.seq;
          rec_minute  <= rd_rec.minute;
          rec_second  <= rd_rec.second;
          rec_code    <= rd_rec.code;
          checksum_ok <= (sum_out == rd_rec.sum);
          count       <= 5'(entry_count);
          last        <= dump_done;
          strobe      <= 1'b1;
          rd_addr     <= rd_addr_inc;
          dump_pos    <= dump_pos_inc;
          state       <= dump_done ? S_IDLE : S_READ;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `CEL_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, entry_count <= CNT_W'(LOG_DEPTH))
  `CEL_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `CEL_ASSERT_SAME(a_more_follow, clk, rst, strobe && !last, busy)
  `CEL_ASSERT_SAME(a_reject_shape, clk, rst, strobe && status, last && !has_record)
  `CEL_ASSERT_SAME(a_dump_sum, clk, rst, strobe && has_record, checksum_ok)

endmodule

@@ bench/event_log_monitor.sv @@
// monitor for the circular event log: watches the command, result and config channels
// keeps its own copy of the log, predicts every reply and compares field by field
// depends on cel_pkg
module event_log_monitor
  import cel_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] func,
  input  logic [5:0] minute,
  input  logic [5:0] second,
  input  logic [7:0] event_code,
  input  logic       strobe,
  input  logic       status,
  input  logic       has_record,
  input  logic [3:0] position,
  input  logic [7:0] seq,
  input  logic [5:0] rec_minute,
  input  logic [5:0] rec_second,
  input  logic [7:0] rec_code,
  input  logic       checksum_ok,
  input  logic [4:0] count,
  input  logic       last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         errors,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic       status;
    logic       has_record;
    logic [3:0] position;
    logic [7:0] seq;
    logic [5:0] minute;
    logic [5:0] second;
    logic [7:0] code;
    logic       sum_ok;
    logic [4:0] count;
    logic       last;
  } log_reply_t;

  // shadow copy of the log and its header
  rec_t       ring [LOG_DEPTH_DEF];
  int         wr_slot;
  int         held;
  logic [7:0] seq_next;
  logic [7:0] limit_reg;
  logic [7:0] extra_reg;

  log_reply_t replies_due [$];

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // work out the replies of one accepted command and update the shadow log
  task automatic log_apply_command(input logic [1:0] f, input logic [5:0] m,
                                   input logic [5:0] s, input logic [7:0] c);
    log_reply_t r;
    rec_t       e;
    int         oldest;
    int         n;
    logic       code_fine;
    r = '{default: '0};
    r.last = 1'b1;
    case (f)
      FUNC_SAVE: begin
        code_fine = (c <= limit_reg) || (c == extra_reg);
        if (!code_fine || m > TIME_LIMIT || s > TIME_LIMIT) begin
          r.status = 1'b1;
        end else begin
          e.seq    = seq_next;
          e.minute = m;
          e.second = s;
          e.code   = c;
          e.sum    = e.seq ^ {2'b00, m} ^ {2'b00, s} ^ c;
          ring[wr_slot] = e;
          wr_slot = (wr_slot + 1) % LOG_DEPTH_DEF;
          if (held < LOG_DEPTH_DEF) held++;
          r.seq = seq_next;
          seq_next = seq_next + 8'd1;
          if (seq_next == 8'd0) seq_next = SEQ_RESTART;
        end
        r.count = held[4:0];
        replies_due.push_back(r);
      end
      FUNC_DUMP: begin
        r.count = held[4:0];
        if (held == 0) begin
          replies_due.push_back(r);
        end else begin
          oldest = (held < LOG_DEPTH_DEF) ? 0 : wr_slot;
          n = (held > MAX_RESULTS) ? MAX_RESULTS : held;
          for (int i = 0; i < n; i++) begin
            e = ring[(oldest + i) % LOG_DEPTH_DEF];
            r.has_record = 1'b1;
            r.position   = i[3:0];
            r.seq        = e.seq;
            r.minute     = e.minute;
            r.second     = e.second;
            r.code       = e.code;
            r.sum_ok     = ((e.seq ^ {2'b00, e.minute} ^ {2'b00, e.second} ^ e.code) == e.sum);
            r.last       = (i == n - 1);
            replies_due.push_back(r);
          end
        end
      end
      FUNC_CLEAR: begin
        wr_slot  = 0;
        held     = 0;
        seq_next = SEQ_RESTART;
        replies_due.push_back(r);
      end
      default: begin
        r.count = held[4:0];
        replies_due.push_back(r);
      end
    endcase
  endtask

  always @(posedge clk) begin
    log_reply_t want;
    if (rst) begin
      wr_slot   = 0;
      held      = 0;
      seq_next  = SEQ_RESTART;
      limit_reg = CODE_LIMIT_RST;
      extra_reg = EXTRA_CODE_RST;
      replies_due.delete();
    end else begin
      // a reply may land on the same edge as the next command, so compare first
      if (strobe) begin
        if (replies_due.size() == 0) begin
          $error("result strobe with no command outstanding");
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", 8'(want.status), 8'(status));
          check_field("has_record", 8'(want.has_record), 8'(has_record));
          check_field("position", 8'(want.position), 8'(position));
          check_field("seq", want.seq, seq);
          check_field("rec_minute", 8'(want.minute), 8'(rec_minute));
          check_field("rec_second", 8'(want.second), 8'(rec_second));
          check_field("rec_code", want.code, rec_code);
          check_field("checksum_ok", 8'(want.sum_ok), 8'(checksum_ok));
          check_field("count", 8'(want.count), 8'(count));
          check_field("last", 8'(want.last), 8'(last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CODE_LIMIT) limit_reg = cfg_data;
        else extra_reg = cfg_data;
      end
      if (start && !busy) log_apply_command(func, minute, second, event_code);
    end
    outstanding = replies_due.size();
  end

endmodule

@@ bench/testbench.sv @@
// top of the circular event log testbench: clock, reset, stimulus and verdict
// instantiates circular_event_log as u_top and event_log_monitor beside it
// depends on cel_pkg
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cel_pkg::*;

  // function code the block ignores
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // longest dump is 16 records
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200000;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       start        = 1'b0;
  logic [1:0] func         = FUNC_SAVE;
  logic [5:0] minute       = '0;
  logic [5:0] second       = '0;
  logic [7:0] event_code   = '0;
  logic       cfg_valid    = 1'b0;
  logic       cfg_index    = CFG_CODE_LIMIT;
  logic [7:0] cfg_data     = '0;

  logic       busy;
  logic       strobe;
  logic       status;
  logic       has_record;
  logic [3:0] position;
  logic [7:0] seq;
  logic [5:0] rec_minute;
  logic [5:0] rec_second;
  logic [7:0] rec_code;
  logic       checksum_ok;
  logic [4:0] count;
  logic       last;
  logic       cfg_ready;

  int bad_results;
  int results_due;
  int cycles = 0;

  // code rules currently programmed, used to aim saves at accepted codes
  logic [7:0] rule_limit = CODE_LIMIT_RST;
  logic [7:0] rule_extra = EXTRA_CODE_RST;

  always #5 clk = ~clk;

  circular_event_log u_top (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .func(func), .minute(minute), .second(second),
    .event_code(event_code),
    .strobe(strobe), .status(status), .has_record(has_record), .position(position),
    .seq(seq), .rec_minute(rec_minute), .rec_second(rec_second), .rec_code(rec_code),
    .checksum_ok(checksum_ok), .count(count), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  event_log_monitor u_check (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .func(func), .minute(minute), .second(second),
    .event_code(event_code),
    .strobe(strobe), .status(status), .has_record(has_record), .position(position),
    .seq(seq), .rec_minute(rec_minute), .rec_second(rec_second), .rec_code(rec_code),
    .checksum_ok(checksum_ok), .count(count), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(bad_results), .outstanding(results_due)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // a code the current rules accept: the extra code or one up to the limit
  function automatic logic [7:0] accepted_code();
    if ($urandom_range(0, 3) == 0) return rule_extra;
    return 8'($urandom_range(0, rule_limit));
  endfunction

  // one command transaction; start stays high into the next one when there is no gap
  task automatic issue(input logic [1:0] f, input logic [5:0] m, input logic [5:0] s,
                       input logic [7:0] c, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    func         <= f;
    minute       <= m;
    second       <= s;
    event_code   <= c;
    do @(posedge clk); while (busy);
  endtask

  // hold off the sender until every predicted reply has come back
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // both code rules in one go, valid held high across the two transactions
  task automatic program_code_rules(input logic [7:0] limit, input logic [7:0] extra);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CODE_LIMIT;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_EXTRA_CODE;
    cfg_data  <= extra;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    rule_limit = limit;
    rule_extra = extra;
  endtask

  // mostly well-formed saves with random content, plus dumps, clears and noise
  task automatic random_command(input bit no_gaps);
    int         roll;
    int         gap;
    logic [1:0] f;
    logic [5:0] m;
    logic [5:0] s;
    logic [7:0] c;
    gap  = no_gaps ? 0 : pick_gap();
    roll = $urandom_range(0, 99);
    m    = 6'($urandom_range(0, 63));
    s    = 6'($urandom_range(0, 63));
    c    = 8'($urandom_range(0, 255));
    if (roll < 65) begin
      f = FUNC_SAVE;
      // one save in five keeps the raw fields and is likely rejected
      if ($urandom_range(0, 4) != 0) begin
        m = 6'($urandom_range(0, 59));
        s = 6'($urandom_range(0, 59));
        c = accepted_code();
      end
    end else if (roll < 90) begin
      f = FUNC_DUMP;
    end else if (roll < 94) begin
      f = FUNC_UNUSED;
    end else begin
      f = FUNC_CLEAR;
    end
    issue(f, m, s, c, gap);
  endtask

  task automatic random_burst(input int n);
    repeat (n) random_command(1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset rules: limit 7, extra 255
    issue(FUNC_DUMP, 6'd0, 6'd0, 8'd0, 0);        // empty log
    issue(FUNC_SAVE, 6'd0, 6'd0, 8'd0, 0);        // all-zero record
    issue(FUNC_SAVE, 6'd59, 6'd59, 8'd7, 0);      // time and code on their limits
    issue(FUNC_SAVE, 6'd12, 6'd34, 8'd255, 1);    // extra code
    issue(FUNC_SAVE, 6'd60, 6'd0, 8'd0, 0);       // minute just out of range
    issue(FUNC_SAVE, 6'd0, 6'd60, 8'd0, 0);       // second just out of range
    issue(FUNC_SAVE, 6'd63, 6'd63, 8'd255, 0);    // both stamps at field maximum
    issue(FUNC_SAVE, 6'd5, 6'd5, 8'd8, 2);        // code one above the limit
    issue(FUNC_SAVE, 6'd5, 6'd5, 8'd254, 0);      // code just below the extra code
    issue(FUNC_UNUSED, 6'd63, 6'd63, 8'd255, 0);  // ignored function code
    issue(FUNC_DUMP, 6'd0, 6'd0, 8'd0, 0);
    issue(FUNC_CLEAR, 6'd0, 6'd0, 8'd0, 0);
    issue(FUNC_DUMP, 6'd0, 6'd0, 8'd0, 0);        // empty again after clear
    issue(FUNC_SAVE, 6'd1, 6'd2, 8'd3, 0);        // numbering restarts at one
    issue(FUNC_DUMP, 6'd0, 6'd0, 8'd0, 0);

    // narrowest rules: only code zero passes
    drain();
    program_code_rules(8'd0, 8'd0);
    issue(FUNC_SAVE, 6'd30, 6'd30, 8'd0, 0);
    issue(FUNC_SAVE, 6'd30, 6'd30, 8'd1, 0);
    random_burst(10);

    // widest rules: every code passes
    drain();
    program_code_rules(8'd255, 8'd0);
    issue(FUNC_SAVE, 6'd42, 6'd17, 8'd255, 0);
    random_burst(10);

    // limit zero with code 255 as the extra one
    drain();
    program_code_rules(8'd0, 8'd255);
    random_burst(10);

    // random rules
    drain();
    program_code_rules(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_burst(10);

    // unbroken run of saves with one dump among them: the log fills and the write slot wraps;
    // no idling in this stretch
    drain();
    program_code_rules(CODE_LIMIT_RST, EXTRA_CODE_RST);
    issue(FUNC_CLEAR, 6'd0, 6'd0, 8'd0, 0);
    for (int i = 0; i < 40; i++) begin
      if (i % 40 == 17) begin
        issue(FUNC_DUMP, 6'd0, 6'd0, 8'd0, 0);
      end else begin
        issue(FUNC_SAVE, 6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
              accepted_code(), 0);
      end
    end
    issue(FUNC_DUMP, 6'd0, 6'd0, 8'd0, 0);

    // wait for the last replies, then a quiet spell to catch stray strobes
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ circular_event_log.f @@
+incdir+rtl/core
rtl/core/cel_pkg.sv
rtl/core/cel_ram.sv
rtl/core/circular_event_log.sv
bench/event_log_monitor.sv
bench/testbench.sv
